>>> sv/alsc_pkg.sv
package alsc_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PASS    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MODE          = 2'd0,
    CFG_TOTAL_SAMPLES = 2'd1,
    CFG_MESSAGE_LEN   = 2'd2
  } cfg_idx_e;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned HeaderLen = 32;
  localparam int unsigned CfgWidth  = 31;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         message_byte;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               byte_taken;
    logic [7:0]         data_byte;
    logic               byte_valid;
    logic [1:0]         phase;
    logic               error;
  } out_t;

  typedef struct packed {
    logic        mode;
    logic [29:0] total_samples;
    logic [30:0] message_length;
  } cfg_t;

  typedef struct packed {
    logic       err;
    logic [1:0] sel;
  } density_t;

  // sparsest density whose sample count fits in the total samples; err if none
  function automatic density_t pick_density(logic [29:0] total, logic [31:0] len);
    logic [34:0] t;
    logic [34:0] l;
    density_t    r;
    t = {5'd0, total};
    l = {3'd0, len};
    r.err = 1'b0;
    if (t > {l[31:0], 3'd0}) begin
      r.sel = 2'd0;
    end else if (t > {l[32:0], 2'd0}) begin
      r.sel = 2'd1;
    end else if (t > {l[33:0], 1'b0}) begin
      r.sel = 2'd2;
    end else begin
      r.sel = 2'd3;
      r.err = (t < l);
    end
    return r;
  endfunction

endpackage

>>> sv/alsc_core.sv
module alsc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  alsc_pkg::in_t  in_i,
  input  alsc_pkg::cfg_t cfg_i,
  output alsc_pkg::out_t res_o
);
  import alsc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  hc_q, hc_d;
  logic [2:0]  ci_q, ci_d;
  logic [31:0] bl_q, bl_d;
  logic [31:0] ls_q, ls_d;
  logic [1:0]  dsel_q, dsel_d;
  logic [7:0]  bw_q, bw_d;
  logic        err_q, err_d;

  logic [15:0] s;
  logic [7:0]  mb;
  logic [31:0] ls_dec;
  logic [31:0] ls_enc;
  logic [31:0] len_sel;
  density_t    dens;
  logic [7:0]  mask;
  logic [3:0]  per_byte;
  logic [2:0]  sh;
  logic [2:0]  ci_n;
  logic        last;
  logic [15:0] os;
  logic [1:0]  ph_out;
  logic        taken;
  logic [7:0]  dbyte;
  logic        dvalid;
  logic [31:0] bl_n;

  assign s  = 16'(in_i.sample);
  assign mb = in_i.message_byte;

  // length word as it stands after this header sample
  assign ls_dec  = ((hc_q == 5'd0) ? 32'd0 : ls_q) | (32'(s[0]) << hc_q);
  assign ls_enc  = (hc_q == 5'd0) ? {1'b0, cfg_i.message_length} : ls_q;
  assign len_sel = (cfg_i.mode == MODE_ENCODE) ? {1'b0, cfg_i.message_length} : ls_dec;
  assign dens    = pick_density(cfg_i.total_samples, len_sel);

  always_comb begin
    case (dsel_q)
      2'd0:    begin mask = 8'h01; per_byte = 4'd8; end
      2'd1:    begin mask = 8'h03; per_byte = 4'd4; end
      2'd2:    begin mask = 8'h0F; per_byte = 4'd2; end
      default: begin mask = 8'hFF; per_byte = 4'd1; end
    endcase
  end

  assign sh   = 3'(ci_q << dsel_q);
  assign ci_n = ci_q + 3'd1;
  assign last = ({1'b0, ci_n} >= per_byte) || (ci_n == 3'd0);
  assign bl_n = bl_q - 32'd1;

  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    ci_d    = ci_q;
    bl_d    = bl_q;
    ls_d    = ls_q;
    dsel_d  = dsel_q;
    bw_d    = bw_q;
    err_d   = err_q;
    os      = s;
    ph_out  = phase_q;
    taken   = 1'b0;
    dbyte   = 8'd0;
    dvalid  = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (cfg_i.mode == MODE_ENCODE && hc_q == 5'd0 && dens.err) begin
          err_d   = 1'b1;
          phase_d = PH_PASS;
          ph_out  = PH_PASS;
        end else begin
          if (cfg_i.mode == MODE_ENCODE) begin
            os   = {s[15:1], ls_enc[0]};
            ls_d = ls_enc >> 1;
          end else begin
            ls_d = ls_dec;
          end
          if (hc_q == 5'(HeaderLen - 1)) begin
            hc_d = 5'd0;
            if (dens.err) begin
              err_d   = 1'b1;
              phase_d = PH_PASS;
            end else begin
              dsel_d  = dens.sel;
              bl_d    = len_sel;
              ci_d    = 3'd0;
              bw_d    = 8'd0;
              phase_d = (len_sel != 32'd0) ? PH_PAYLOAD : PH_PASS;
            end
          end else begin
            hc_d = hc_q + 5'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        ci_d = ci_n;
        if (cfg_i.mode == MODE_ENCODE) begin
          os    = (s & ~{8'h00, mask}) | {8'h00, (mb >> sh) & mask};
          taken = last;
        end else begin
          bw_d = bw_q | ((s[7:0] & mask) << sh);
          if (last) begin
            dbyte  = bw_d;
            dvalid = 1'b1;
            bw_d   = 8'd0;
          end
        end
        if (last) begin
          ci_d = 3'd0;
          bl_d = bl_n;
          if (bl_n == 32'd0) begin
            phase_d = PH_PASS;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.out_sample = os;
  assign res_o.byte_taken = taken;
  assign res_o.data_byte  = dbyte;
  assign res_o.byte_valid = dvalid;
  assign res_o.phase      = ph_out;
  assign res_o.error      = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q    <= '0;
      ci_q    <= '0;
      bl_q    <= '0;
      ls_q    <= '0;
      dsel_q  <= '0;
      bw_q    <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      ci_q    <= ci_d;
      bl_q    <= bl_d;
      ls_q    <= ls_d;
      dsel_q  <= dsel_d;
      bw_q    <= bw_d;
      err_q   <= err_d;
    end
  end

  // error is sticky until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag cleared");

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.byte_taken && res_o.byte_valid))
    else $error("byte taken and byte valid together");

  a_pass_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_PASS) |-> (!res_o.byte_taken && !res_o.byte_valid))
    else $error("byte activity in pass-through");

  a_header_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (hc_q == 5'd0))
    else $error("header count left nonzero");

endmodule

>>> sv/audio_lsb_stego_codec.sv
// throughput: one word per cycle while the output is not stalled; the input
// register and the result register form a two-stage pipeline with a
// single state update stage between them
// reset: asynchronous active low; clears configuration, codec state and
// pipeline valids, the block starts in the length header phase
module audio_lsb_stego_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  alsc_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output alsc_pkg::out_t       out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i
);
  import alsc_pkg::*;

  cfg_t cfg_q;
  in_t  in_q;
  logic in_vld_q;
  out_t out_q;
  logic out_vld_q;
  out_t res;
  logic adv;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:          cfg_q.mode           <= cfg_data_i[0];
        CFG_TOTAL_SAMPLES: cfg_q.total_samples  <= cfg_data_i[29:0];
        CFG_MESSAGE_LEN:   cfg_q.message_length <= cfg_data_i[CfgWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  alsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .in_i   (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alsc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_MODE;
  logic [30:0] cfg_data = '0;

  audio_lsb_stego_codec dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial forever #5 clk = ~clk;

  in_t  pending_samples[$];
  out_t due_results[$];
  logic word_sent = 1'b0;
  int   bad_words = 0;

  // codec copy: configuration and stream state
  logic        cfg_mode = MODE_ENCODE;
  logic [29:0] cfg_total = '0;
  logic [30:0] cfg_len = '0;
  phase_e      codec_phase = PH_HEADER;
  logic [4:0]  hdr_cnt = '0;
  logic [2:0]  chunk = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] len_sh = '0;
  logic [1:0]  dens = '0;
  logic [7:0]  work = '0;
  logic        err_f = 1'b0;

  // {too_long, density select} for a message length
  function automatic logic [2:0] density_for(logic [31:0] len);
    logic [63:0] t;
    logic [63:0] l;
    t = 64'(cfg_total);
    l = 64'(len);
    if (t > l * 8) return {1'b0, 2'd0};
    if (t > l * 4) return {1'b0, 2'd1};
    if (t > l * 2) return {1'b0, 2'd2};
    return {t < l, 2'd3};
  endfunction

  task automatic header_advance(input logic [31:0] len);
    logic [2:0] fit;
    if (hdr_cnt == 5'd31) begin
      hdr_cnt = '0;
      fit = density_for(len);
      if (fit[2]) begin
        err_f = 1'b1;
        codec_phase = PH_PASS;
      end else begin
        dens = fit[1:0];
        bytes_left = len;
        chunk = '0;
        work = '0;
        codec_phase = (len != 0) ? PH_PAYLOAD : PH_PASS;
      end
    end else begin
      hdr_cnt = hdr_cnt + 5'd1;
    end
  endtask

  task automatic stego_step(input in_t w, output out_t r);
    logic [15:0] s;
    logic [7:0]  mb;
    logic [2:0]  fit;
    phase_e      ph;
    int unsigned nbits;
    int unsigned per_byte;
    int unsigned sh;
    logic [7:0]  mask;
    logic [15:0] piece;
    logic        last;
    logic        ok;
    s = w.sample;
    mb = w.message_byte;
    r = '0;
    r.out_sample = s;
    ph = codec_phase;
    ok = 1'b1;
    case (ph)
      PH_HEADER: begin
        if (cfg_mode == MODE_ENCODE) begin
          if (hdr_cnt == 0) begin
            fit = density_for(32'(cfg_len));
            if (fit[2]) begin
              err_f = 1'b1;
              codec_phase = PH_PASS;
              ph = PH_PASS;
              ok = 1'b0;
            end else begin
              len_sh = 32'(cfg_len);
            end
          end
          if (ok) begin
            r.out_sample = {s[15:1], len_sh[0]};
            len_sh = len_sh >> 1;
            header_advance(32'(cfg_len));
          end
        end else begin
          if (hdr_cnt == 0) len_sh = '0;
          len_sh[hdr_cnt] = len_sh[hdr_cnt] | s[0];
          header_advance(len_sh);
        end
      end
      PH_PAYLOAD: begin
        nbits = 1 << dens;
        per_byte = 8 / nbits;
        mask = 8'((1 << nbits) - 1);
        sh = (chunk * nbits) & 7;
        chunk = chunk + 3'd1;
        last = (chunk >= per_byte) || (chunk == 0);
        if (cfg_mode == MODE_ENCODE) begin
          r.out_sample = (s & ~{8'h00, mask}) | {8'h00, (mb >> sh) & mask};
          r.byte_taken = last;
        end else begin
          piece = (s & {8'h00, mask}) << sh;
          work = work | piece[7:0];
          if (last) begin
            r.data_byte = work;
            r.byte_valid = 1'b1;
            work = '0;
          end
        end
        if (last) begin
          chunk = '0;
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) codec_phase = PH_PASS;
        end
      end
      default: ;
    endcase
    r.phase = ph;
    r.error = err_f;
  endtask

  function automatic string show(out_t v);
    return $sformatf("sample %04h taken %0d byte %02h valid %0d phase %0d error %0d",
                     v.out_sample, v.byte_taken, v.data_byte, v.byte_valid, v.phase,
                     v.error);
  endfunction

  always @(posedge clk) begin : scoreboard
    out_t want;
    out_t got;
    out_t r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("unexpected word: %s", show(got));
        end else begin
          want = due_results.pop_front();
          if (got.out_sample !== want.out_sample || got.byte_taken !== want.byte_taken ||
              got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
              got.phase !== want.phase || got.error !== want.error) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("mismatch: expected %s", show(want));
              $display("          actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MODE:          cfg_mode = cfg_data[0];
          CFG_TOTAL_SAMPLES: cfg_total = cfg_data[29:0];
          CFG_MESSAGE_LEN:   cfg_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        stego_step(in_data, r);
        due_results.push_back(r);
      end
    end
    word_sent <= rst_n && in_valid && !in_stall;
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !word_sent)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_data <= pending_samples.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: windows of varying stall rate, one long hold-off
  int  hold_left = 0;
  logic hold_done = 1'b0;
  int  win_left = 0;
  int  stall_pct = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rst_n && !hold_done && pending_samples.size() > 20) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall <= 1'b1;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(16, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      win_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic queue_word(input logic [15:0] s, input logic [7:0] b);
    in_t w;
    w.sample = s;
    w.message_byte = b;
    pending_samples.push_back(w);
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          kind;
    int          k;
    int          per_byte;
    int          nb;
    int          used;
    int          pass_n;
    int          i;
    int          j;
    logic [31:0] hlen;
    logic [29:0] tot;
    logic [30:0] mlen;
    logic        hdr_mode;
    logic        cur_mode;
    logic [15:0] s;
    logic [7:0]  b;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stream shape: density 0..3, too long, or empty message
    kind = $urandom_range(0, 9);
    hdr_mode = $urandom_range(0, 1);
    hlen = $urandom_range(1, 40);
    k = kind % 4;
    tot = '0;
    if (kind < 8) begin
      case (k)
        0: tot = ($urandom_range(0, 3) == 0) ? 30'h3FFFFFFF
                                               : 30'(8 * hlen + 1 + $urandom_range(0, 500));
        1: tot = 30'($urandom_range(4 * hlen + 1, 8 * hlen));
        2: tot = 30'($urandom_range(2 * hlen + 1, 4 * hlen));
        default: tot = 30'($urandom_range(hlen, 2 * hlen));
      endcase
    end else if (kind == 8) begin
      if ($urandom_range(0, 1) == 0) begin
        hlen = (hdr_mode == MODE_DECODE) ? 32'hFFFFFFFF : 32'h7FFFFFFF;
        tot = 30'h3FFFFFFF;
      end else begin
        hlen = $urandom_range(50, 1000);
        tot = 30'($urandom_range(0, hlen - 1));
      end
    end else begin
      hlen = '0;
      tot = ($urandom_range(0, 1) == 0) ? 30'h0 : 30'($urandom);
    end
    nb = (kind < 8) ? int'(hlen) : 0;
    per_byte = 8 >> k;
    mlen = (hdr_mode == MODE_ENCODE) ? hlen[30:0] : 31'($urandom);

    write_reg(CFG_TOTAL_SAMPLES, {1'b0, tot});
    write_reg(CFG_MESSAGE_LEN, mlen);
    write_reg(CFG_MODE, {30'd0, hdr_mode});

    for (i = 0; i < 32; i++) begin
      case (i)
        0: s = 16'h8000;
        1: s = 16'h7FFF;
        2: s = 16'h0000;
        3: s = 16'hFFFF;
        default: s = 16'($urandom);
      endcase
      s[0] = hlen[i];
      queue_word(s, 8'($urandom));
    end

    // payload, with mode flips at byte boundaries
    cur_mode = hdr_mode;
    for (j = 0; j < nb; j++) begin
      if (j > 0 && $urandom_range(0, 7) == 0) begin
        settle();
        cur_mode = ~cur_mode;
        write_reg(CFG_MODE, {30'd0, cur_mode});
      end
      case (j)
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = 8'hA5;
        3: b = 8'h5A;
        default: b = 8'($urandom);
      endcase
      for (i = 0; i < per_byte; i++) begin
        s = (j < 2) ? {16{j[0]}} : 16'($urandom);
        if ($urandom_range(0, 19) == 0) queue_word(s, 8'($urandom));
        else queue_word(s, b);
      end
    end
    used = 32 + nb * per_byte;
    pass_n = 900 - used;

    settle();
    write_reg(CFG_TOTAL_SAMPLES, 31'h3FFFFFFF);
    write_reg(CFG_MESSAGE_LEN, 31'h7FFFFFFF);
    write_reg(CFG_MODE, {30'd0, ~cur_mode});
    for (i = 0; i < pass_n / 2; i++) queue_word(16'($urandom), 8'($urandom));

    settle();
    write_reg(CFG_TOTAL_SAMPLES, 31'h0);
    write_reg(CFG_MESSAGE_LEN, 31'h0);
    write_reg(CFG_MODE, {30'd0, 1'($urandom)});
    for (i = pass_n / 2; i < pass_n; i++) queue_word(16'($urandom), 8'($urandom));

    settle();
    repeat (4) @(posedge clk);
    if (bad_words == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
